@@ hdl/mcrl_pkg.sv @@
package mcrl_pkg;

  // Field widths fixed by the interface.
  localparam int TGT_W   = 16;
  localparam int MS_W    = 16;
  localparam int SCALE_W = 15;
  localparam int TICK_W  = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 3'd4;

  // Timing constants.
  localparam int TICKS_PER_MS    = 4;
  localparam int RELEASE_CAP_MS  = 3000;
  localparam int UP_DEFAULT_MS   = 600;
  localparam int DOWN_DEFAULT_MS = 1000;
  localparam int FALLBACK_RESET  = 4096;

  // Default number of fraction bits in the reference.
  localparam int FRAC_BITS_DEF = 8;

  // Settings derived from the configuration registers.
  typedef struct packed {
    logic [TICK_W-1:0]  rise_ticks;
    logic [TICK_W-1:0]  down_ticks;
    logic [TICK_W-1:0]  release_ticks;
    logic               release_en;
    logic [SCALE_W-1:0] scale;
  } mcrl_cfg_t;

endpackage

@@ hdl/motor_current_ramp_limiter_unit.sv @@
// Slew-rate limiter for a motor current command. Each accepted item is one
// control tick; it yields exactly one current_command. A new item is taken
// only once the previous one is through: the step size comes from a
// bit-serial divider that produces one quotient bit per cycle over the
// 15 + FRAC_BITS bit dividend, around which sit the prepare and start
// states, the wait that collects the quotient, the update and rounding
// states and the idle state in which the next item is accepted. The result
// sits in an output register, so the next item may be taken while it
// waits; only a result still held there when the next tick reaches
// rounding stretches that tick. Configuration writes are taken in any
// cycle and must only be issued while no item is in progress.
module motor_current_ramp_limiter_unit #(
  parameter int FRAC_BITS = mcrl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mcrl_pkg::TGT_W-1:0] in_target_current,
  input  logic                             in_cut_now,
  input  logic                             in_zero_now,
  input  logic                             in_walk_mode,
  input  logic                             in_coast_mode,
  input  logic                             in_pedaling,
  // Result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mcrl_pkg::TGT_W-1:0] out_current_command,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcrl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcrl_pkg::*;

  localparam int ACC_W = TGT_W + FRAC_BITS + 2;
  localparam int MAG_W = ACC_W - 1;
  localparam int DIV_W = SCALE_W + FRAC_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_RND   = 3'd5;

  mcrl_cfg_t cfg;

  logic [2:0]              state_r, state_nxt;
  logic signed [TGT_W-1:0] tgt_r, tgt_nxt;
  logic                    clr_r, clr_nxt;
  logic                    walk_r, walk_nxt;
  logic                    pedal_r, pedal_nxt;
  logic signed [ACC_W-1:0] ref_r, ref_nxt;
  logic [DIV_W-1:0]        fade_r, fade_nxt;
  logic signed [ACC_W-1:0] diff_r, diff_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    gt_r, gt_nxt;
  logic                    lt_r, lt_nxt;
  logic                    use_fade_r, use_fade_nxt;
  logic [DIV_W-1:0]        step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [TGT_W-1:0] out_cmd_r, out_cmd_nxt;

  logic signed [ACC_W-1:0] tgt_q;
  logic                    tgt_zero;
  logic                    diff_gt, diff_lt, fading;
  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_dividend, div_q;
  logic [TICK_W-1:0]       div_ticks;
  logic [MAG_W-1:0]        move;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [TGT_W-1:0] rnd_res;
  logic                    out_free;

  mcrl_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcrl_serial_div #(
    .DIV_W (DIV_W),
    .DEN_W (TICK_W)
  ) u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (div_start),
    .dividend      (div_dividend),
    .divisor       (div_ticks),
    .done          (div_done),
    .quotient_ceil (div_q)
  );

  // Target in the fixed-point format of the reference.
  assign tgt_q    = {{2{tgt_r[TGT_W-1]}}, tgt_r, {FRAC_BITS{1'b0}}};
  assign tgt_zero = (tgt_r == '0);

  // Direction and fade decision from the registered difference.
  assign diff_lt = diff_r[ACC_W-1];
  assign diff_gt = !diff_r[ACC_W-1] && (diff_r != '0);
  assign fading  = tgt_zero && !pedal_r && cfg.release_en;

  // Divider operands: a fresh fade spreads the reference, otherwise the
  // full-scale current is spread over the ramp time.
  assign div_start    = (state_r == S_START);
  assign div_ticks    = diff_gt ? cfg.rise_ticks
                      : (fading ? cfg.release_ticks : cfg.down_ticks);
  assign div_dividend = (fading && diff_lt) ? ref_r[DIV_W-1:0]
                                            : {cfg.scale, {FRAC_BITS{1'b0}}};

  // Move limited to one step.
  assign move = (mag_r > MAG_W'(step_r)) ? MAG_W'(step_r) : mag_r;

  // Rounding with halves upward.
  assign rnd_sum = ref_r + ACC_W'(1 << (FRAC_BITS - 1));
  assign rnd_res = rnd_sum[FRAC_BITS +: TGT_W];

  assign out_free = !out_valid_r || !out_stall;

  // Tick sequencer.
  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    clr_nxt       = clr_r;
    walk_nxt      = walk_r;
    pedal_nxt     = pedal_r;
    ref_nxt       = ref_r;
    fade_nxt      = fade_r;
    diff_nxt      = diff_r;
    mag_nxt       = mag_r;
    gt_nxt        = gt_r;
    lt_nxt        = lt_r;
    use_fade_nxt  = use_fade_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cmd_nxt   = out_cmd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_target_current;
          clr_nxt   = in_cut_now || in_zero_now ||
                      (!in_walk_mode && in_coast_mode && (in_target_current == '0));
          walk_nxt  = in_walk_mode;
          pedal_nxt = in_pedaling;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        diff_nxt  = tgt_q - ref_r;
        state_nxt = S_START;
      end
      S_START: begin
        gt_nxt       = diff_gt;
        lt_nxt       = diff_lt;
        use_fade_nxt = fading && diff_lt;
        mag_nxt      = diff_lt ? MAG_W'(-diff_r) : MAG_W'(diff_r);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (use_fade_r) begin
            if (fade_r == '0) begin
              fade_nxt = div_q;
              step_nxt = div_q;
            end else begin
              step_nxt = fade_r;
            end
          end else begin
            fade_nxt = '0;
            step_nxt = div_q;
          end
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (clr_r) begin
          ref_nxt  = '0;
          fade_nxt = '0;
        end else if (walk_r) begin
          ref_nxt  = tgt_q;
          fade_nxt = '0;
        end else if (gt_r) begin
          ref_nxt = ref_r + $signed({1'b0, move});
        end else if (lt_r) begin
          ref_nxt = ref_r - $signed({1'b0, move});
        end
        state_nxt = S_RND;
      end
      S_RND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = rnd_res;
          // A finished fade clears the state, which arms the next one.
          if (tgt_zero && (rnd_res == '0)) begin
            ref_nxt  = '0;
            fade_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_r       <= '0;
      fade_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r      <= tgt_nxt;
    clr_r      <= clr_nxt;
    walk_r     <= walk_nxt;
    pedal_r    <= pedal_nxt;
    diff_r     <= diff_nxt;
    mag_r      <= mag_nxt;
    gt_r       <= gt_nxt;
    lt_r       <= lt_nxt;
    use_fade_r <= use_fade_nxt;
    step_r     <= step_nxt;
    out_cmd_r  <= out_cmd_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_current_command = out_cmd_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_PREP)
    else $error("accepted transfer did not start a tick");
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the wait state");
  a_walk_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && walk_r && !clr_r) |-> rnd_res == tgt_r)
    else $error("walk mode command differs from target");
  a_fade_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && out_free && tgt_zero && rnd_res == '0) |=>
      (ref_r == '0 && fade_r == '0))
    else $error("finished fade left state behind");
  a_fade_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fade_r != '0) |-> (ref_r > 0))
    else $error("fade armed without a positive reference");

endmodule

@@ hdl/mcrl_regs.sv @@
module mcrl_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcrl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mcrl_pkg::mcrl_cfg_t              cfg
);
  import mcrl_pkg::*;

  logic [MS_W-1:0]    ramp_up_ms_r, ramp_up_ms_nxt;
  logic [MS_W-1:0]    ramp_down_ms_r, ramp_down_ms_nxt;
  logic [MS_W-1:0]    release_ms_r, release_ms_nxt;
  logic [SCALE_W-1:0] current_scale_r, current_scale_nxt;
  logic [SCALE_W-1:0] fallback_scale_r, fallback_scale_nxt;
  logic [MS_W-1:0]    up_ms, down_ms, rel_ms;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write decode; indexes beyond the list are ignored.
  always_comb begin
    ramp_up_ms_nxt     = ramp_up_ms_r;
    ramp_down_ms_nxt   = ramp_down_ms_r;
    release_ms_nxt     = release_ms_r;
    current_scale_nxt  = current_scale_r;
    fallback_scale_nxt = fallback_scale_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_RAMP_UP:   ramp_up_ms_nxt     = cfg_data;
        REG_RAMP_DOWN: ramp_down_ms_nxt   = cfg_data;
        REG_RELEASE:   release_ms_nxt     = cfg_data;
        REG_SCALE:     current_scale_nxt  = cfg_data[SCALE_W-1:0];
        REG_FALLBACK:  fallback_scale_nxt = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_up_ms_r     <= '0;
      ramp_down_ms_r   <= '0;
      release_ms_r     <= '0;
      current_scale_r  <= '0;
      fallback_scale_r <= SCALE_W'(FALLBACK_RESET);
    end else begin
      ramp_up_ms_r     <= ramp_up_ms_nxt;
      ramp_down_ms_r   <= ramp_down_ms_nxt;
      release_ms_r     <= release_ms_nxt;
      current_scale_r  <= current_scale_nxt;
      fallback_scale_r <= fallback_scale_nxt;
    end
  end

  // Ramp times with their defaults, and the capped release time.
  assign up_ms   = (ramp_up_ms_r != '0) ? ramp_up_ms_r : MS_W'(UP_DEFAULT_MS);
  assign down_ms = (ramp_down_ms_r != '0) ? ramp_down_ms_r : MS_W'(DOWN_DEFAULT_MS);
  assign rel_ms  = (release_ms_r > MS_W'(RELEASE_CAP_MS)) ? MS_W'(RELEASE_CAP_MS)
                                                           : release_ms_r;

  // Conversion to control ticks and choice of the full-scale current.
  always_comb begin
    cfg.rise_ticks    = TICK_W'(up_ms) * TICK_W'(TICKS_PER_MS);
    cfg.down_ticks    = TICK_W'(down_ms) * TICK_W'(TICKS_PER_MS);
    cfg.release_ticks = TICK_W'(rel_ms) * TICK_W'(TICKS_PER_MS);
    cfg.release_en    = (release_ms_r != '0);
    if (current_scale_r != '0) begin
      cfg.scale = current_scale_r;
    end else if (fallback_scale_r != '0) begin
      cfg.scale = fallback_scale_r;
    end else begin
      cfg.scale = SCALE_W'(1);
    end
  end

endmodule

@@ hdl/mcrl_serial_div.sv @@
module mcrl_serial_div #(
  parameter int DIV_W = mcrl_pkg::SCALE_W + mcrl_pkg::FRAC_BITS_DEF,
  parameter int DEN_W = mcrl_pkg::TICK_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient_ceil
);
  import mcrl_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  // Trial subtraction of the divisor from the partial remainder with the
  // next dividend bit shifted in.
  assign trial = {rem_r, num_r[DIV_W-1]} - {1'b0, den_r};

  // Restoring division: the dividend shifts out at the top while quotient
  // bits shift in at the bottom, one bit per cycle.
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DEN_W]) begin
        rem_nxt = trial[DEN_W-1:0];
      end else begin
        rem_nxt = {rem_r[DEN_W-2:0], num_r[DIV_W-1]};
      end
      num_nxt = {num_r[DIV_W-2:0], !trial[DEN_W]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // Round up when anything is left over.
  assign done          = done_r;
  assign quotient_ceil = num_r + DIV_W'(rem_r != '0);

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule
